// ===== design/ced_pkg.sv =====
// Shared types and constants for the C escape sequence decoder.
// Depends on nothing; every design file refers to it by scoped names.
package ced_pkg;

  // One input word: a raw character or an end-of-string marker.
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_marker;
  } in_t;

  // One output word: a decoded byte or the done result.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       done_res;
    logic       syntax_error;
  } out_t;

  // Work handed from the parser to the output side: one or two output words.
  typedef struct packed {
    logic two;
    out_t res0;
    out_t res1;
  } cmd_t;

  // Command queue sizing.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

endpackage

// ===== design/ced_front.sv =====
// Parser front end of the C escape sequence decoder: tracks escape state
// and turns each accepted word into a command of zero, one or two outputs.
// Depends on ced_pkg.
module ced_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  ced_pkg::in_t  word,
  output logic          push,
  output ced_pkg::cmd_t cmd
);

  // Parser modes.
  localparam logic [2:0] PLAIN = 3'd0;
  localparam logic [2:0] ESC   = 3'd1;
  localparam logic [2:0] HEX0  = 3'd2;
  localparam logic [2:0] HEX1  = 3'd3;
  localparam logic [2:0] OCT1  = 3'd4;
  localparam logic [2:0] OCT2  = 3'd5;

  // Characters with a special meaning.
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_7      = 8'h37;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_LA     = 8'h61;
  localparam logic [7:0] CHAR_LF     = 8'h66;
  localparam logic [7:0] CHAR_UA     = 8'h41;
  localparam logic [7:0] CHAR_UF     = 8'h46;

  // Hex digit decode: bit 4 is set when the character is a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] diff;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      diff = c - CHAR_0;
      return {1'b1, diff[3:0]};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      diff = c - CHAR_LA + 8'd10;
      return {1'b1, diff[3:0]};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      diff = c - CHAR_UA + 8'd10;
      return {1'b1, diff[3:0]};
    end
    return 5'd0;
  endfunction

  // Simple escapes map to control codes; anything else stands for itself.
  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    unique case (c)
      8'h6E:   return 8'h0A;  // n
      8'h72:   return 8'h0D;  // r
      8'h62:   return 8'h08;  // b
      8'h74:   return 8'h09;  // t
      8'h66:   return 8'h0C;  // f
      8'h61:   return 8'h07;  // a
      8'h76:   return 8'h0B;  // v
      default: return c;
    endcase
  endfunction

  function automatic ced_pkg::out_t byte_word(input logic [7:0] b);
    ced_pkg::out_t w;
    w.byte_out     = b;
    w.done_res     = 1'b0;
    w.syntax_error = 1'b0;
    return w;
  endfunction

  function automatic ced_pkg::out_t done_word(input logic err);
    ced_pkg::out_t w;
    w.byte_out     = 8'd0;
    w.done_res     = 1'b1;
    w.syntax_error = err;
    return w;
  endfunction

  logic [2:0] mode, mode_next;
  logic [7:0] accum, accum_next;
  logic       err, err_next;
  logic       emit;
  logic [7:0] c;
  logic [4:0] hex;
  logic       is_oct;

  assign c      = word.char_in;
  assign hex    = hex_digit(c);
  assign is_oct = (c >= CHAR_0) && (c <= CHAR_7);

  // Next state and the outputs that this word completes.
  always_comb begin
    mode_next = mode;
    accum_next = accum;
    err_next = err;
    emit = 1'b0;
    cmd.two = 1'b0;
    cmd.res0 = byte_word(c);
    cmd.res1 = byte_word(c);

    if (word.end_marker) begin
      emit = 1'b1;
      mode_next = PLAIN;
      accum_next = 8'd0;
      err_next = 1'b0;
      unique case (mode) inside
        HEX1: begin
          cmd.two = 1'b1;
          cmd.res0 = byte_word(accum);
          cmd.res1 = done_word(err);
        end
        ESC, HEX0, OCT1, OCT2: begin
          cmd.res0 = done_word(1'b1);
        end
        default: begin
          cmd.res0 = done_word(err);
        end
      endcase
    end else begin
      unique case (mode) inside
        ESC: begin
          mode_next = PLAIN;
          if (c == CHAR_X) begin
            mode_next = HEX0;
          end else if (is_oct) begin
            accum_next = {5'd0, c[2:0]};
            mode_next = OCT1;
          end else begin
            emit = 1'b1;
            cmd.res0 = byte_word(simple_escape(c));
          end
        end
        HEX0: begin
          if (!hex[4]) begin
            err_next = 1'b1;
            mode_next = PLAIN;
          end else begin
            accum_next = {4'd0, hex[3:0]};
            mode_next = HEX1;
          end
        end
        HEX1: begin
          mode_next = PLAIN;
          accum_next = 8'd0;
          emit = 1'b1;
          if (hex[4]) begin
            cmd.res0 = byte_word({accum[3:0], hex[3:0]});
          end else begin
            // The one-digit value goes out, then the character is plain text.
            cmd.res0 = byte_word(accum);
            if (c == CHAR_BSLASH) begin
              mode_next = ESC;
            end else begin
              cmd.two = 1'b1;
              cmd.res1 = byte_word(c);
            end
          end
        end
        OCT1, OCT2: begin
          if (!is_oct) begin
            err_next = 1'b1;
            mode_next = PLAIN;
            accum_next = 8'd0;
          end else if (mode == OCT1) begin
            accum_next = {accum[4:0], c[2:0]};
            mode_next = OCT2;
          end else begin
            emit = 1'b1;
            cmd.res0 = byte_word({accum[4:0], c[2:0]});
            accum_next = 8'd0;
            mode_next = PLAIN;
          end
        end
        default: begin
          mode_next = PLAIN;
          if (c == CHAR_BSLASH) begin
            mode_next = ESC;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
    end
  end

  assign push = accept && emit;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= PLAIN;
      accum <= 8'd0;
      err <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      accum <= accum_next;
      err <= err_next;
    end
  end

endmodule

// ===== design/ced_queue.sv =====
// Short command queue between the parser and the output stage.
// Depends on ced_pkg for the command type and depth.
module ced_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ced_pkg::cmd_t push_data,
  input  logic          pop,
  output ced_pkg::cmd_t pop_data,
  output logic          not_empty,
  output logic          full
);

  ced_pkg::cmd_t            slots [ced_pkg::QDepth];
  logic [ced_pkg::QAw-1:0]  wr_ptr;
  logic [ced_pkg::QAw-1:0]  rd_ptr;
  logic [ced_pkg::QAw:0]    count;

  assign not_empty = (count != '0);
  assign full      = (count == (ced_pkg::QAw+1)'(ced_pkg::QDepth));
  assign pop_data  = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/ced_back.sv =====
// Output stage of the C escape sequence decoder: takes commands from the
// queue and sends their one or two words through a registered output.
// Depends on ced_pkg.
module ced_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ced_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output ced_pkg::out_t out_data
);

  logic          pend;
  ced_pkg::out_t second;
  logic          load;

  // The output register may be refilled when empty or being taken.
  assign load  = !out_valid || out_ready;
  assign q_pop = load && !pend && q_valid;

  // Control: output valid and the pending second word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pend <= q_data.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_data <= second;
      end else if (q_valid) begin
        out_data <= q_data.res0;
        second <= q_data.res1;
      end
    end
  end

endmodule

// ===== design/c_escape_sequence_decoder.sv =====
// C escape sequence decoder top level: parser, command queue, output stage.
// Depends on ced_pkg, ced_front, ced_queue and ced_back.
//
// Accepts one raw character of a C string literal, or an end marker, per
// cycle and delivers the decoded bytes, followed by a done word carrying the
// sticky syntax error flag at each end marker. The parser takes a word every
// cycle while the four-entry command queue has room. The registered output
// stage sends one word per cycle while out_ready is high, so a character
// that completes two words (a one-digit hex escape closed by an ordinary
// character, or an end marker after one hex digit) takes two output words;
// the queue absorbs such bursts.
module c_escape_sequence_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ced_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ced_pkg::out_t out_data
);

  logic          accept;
  logic          push;
  ced_pkg::cmd_t cmd;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  ced_pkg::cmd_t q_data;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  ced_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (in_data),
    .push   (push),
    .cmd    (cmd)
  );

  ced_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  ced_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The parser never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command pushed into full queue");

  // A done word always carries a zero byte.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> (out_data.byte_out == 8'd0))
    else $error("done word with nonzero byte");

  // The error flag only appears on a done word.
  a_err_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.done_res) |-> !out_data.syntax_error)
    else $error("syntax error flag on a byte word");

  // An end marker accepted into an empty pipeline reaches the queue in the next cycle.
  a_end_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.end_marker && !q_valid && !out_valid) |=> q_valid)
    else $error("end marker produced no command");

endmodule

// ===== verif/ced_tb_pkg.sv =====
// Decode checker for the C escape sequence decoder testbench: character
// helpers, a cycle-free decoder of its own, and the store of decoded words.
// Depends on ced_pkg for the input and output word types.
package ced_tb_pkg;

  import ced_pkg::*;

  // Characters that steer the escape grammar.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  // Escape letters that map to a fixed code, plus the quoting escapes.
  localparam string SIMPLE_LETTERS = "nrbtfav\\\"'?";

  // Parser states of the decoder.
  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX0,
    MODE_HEX1,
    MODE_OCT1,
    MODE_OCT2
  } parse_mode_e;

  // Value of a hex digit, or -1 when the character is not one.
  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Value of an octal digit, or -1 when the character is not one.
  function automatic int oct_digit(logic [7:0] c);
    if (c >= "0" && c <= "7") return int'(c - "0");
    return -1;
  endfunction

  // Byte produced by a backslash and a letter that is not x or octal.
  function automatic logic [7:0] escape_code(logic [7:0] c);
    case (c)
      "n": return 8'h0A;
      "r": return 8'h0D;
      "b": return 8'h08;
      "t": return 8'h09;
      "f": return 8'h0C;
      "a": return 8'h07;
      "v": return 8'h0B;
      default: return c;
    endcase
  endfunction

  class decode_checker;
    parse_mode_e mode;
    logic [7:0]  accum;
    bit          err_flag;
    out_t        decoded_q[$];
    int          mismatches;

    function new();
      mode       = MODE_PLAIN;
      accum      = '0;
      err_flag   = 1'b0;
      mismatches = 0;
    endfunction

    function void queue_byte(logic [7:0] b);
      out_t w;
      w.byte_out     = b;
      w.done_res     = 1'b0;
      w.syntax_error = 1'b0;
      decoded_q.push_back(w);
    endfunction

    // A character seen in plain text either opens an escape or passes.
    function void take_plain(logic [7:0] c);
      if (c == CH_BACKSLASH) begin
        mode = MODE_ESC;
      end else begin
        queue_byte(c);
      end
    endfunction

    // Advance the decoder by one accepted input word.
    function void decode_word(in_t w);
      int         d;
      logic [7:0] c;
      logic [7:0] v;
      out_t       done_w;
      c = w.char_in;
      if (w.end_marker) begin
        // A lone hex digit is complete at the end; any other open escape is not.
        if (mode == MODE_HEX1) begin
          queue_byte(accum);
        end else if (mode != MODE_PLAIN) begin
          err_flag = 1'b1;
        end
        done_w.byte_out     = 8'h00;
        done_w.done_res     = 1'b1;
        done_w.syntax_error = err_flag;
        decoded_q.push_back(done_w);
        mode     = MODE_PLAIN;
        accum    = '0;
        err_flag = 1'b0;
        return;
      end
      case (mode)
        MODE_ESC: begin
          mode = MODE_PLAIN;
          if (c == CH_LOWER_X) begin
            mode = MODE_HEX0;
          end else if (oct_digit(c) >= 0) begin
            accum = 8'(oct_digit(c));
            mode  = MODE_OCT1;
          end else begin
            queue_byte(escape_code(c));
          end
        end
        MODE_HEX0: begin
          d = hex_digit(c);
          if (d < 0) begin
            err_flag = 1'b1;
            mode     = MODE_PLAIN;
          end else begin
            accum = 8'(d);
            mode  = MODE_HEX1;
          end
        end
        MODE_HEX1: begin
          // A non-hex character closes the escape and is then read as text.
          d    = hex_digit(c);
          mode = MODE_PLAIN;
          if (d >= 0) begin
            queue_byte({accum[3:0], 4'(d)});
          end else begin
            queue_byte(accum);
            take_plain(c);
          end
          accum = '0;
        end
        MODE_OCT1, MODE_OCT2: begin
          d = oct_digit(c);
          if (d < 0) begin
            err_flag = 1'b1;
            mode     = MODE_PLAIN;
            accum    = '0;
          end else begin
            // Three octal digits can exceed a byte; the top bit falls off.
            v = {accum[4:0], 3'(d)};
            if (mode == MODE_OCT1) begin
              accum = v;
              mode  = MODE_OCT2;
            end else begin
              queue_byte(v);
              accum = '0;
              mode  = MODE_PLAIN;
            end
          end
        end
        default: begin
          mode = MODE_PLAIN;
          take_plain(c);
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one delivered word with the oldest decoded word.
    task check_word(out_t got);
      out_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("word with nothing pending: byte=%02h done=%0b err=%0b",
                         got.byte_out, got.done_res, got.syntax_error));
        return;
      end
      want = decoded_q.pop_front();
      if (got.byte_out !== want.byte_out)
        report($sformatf("byte_out %02h, wanted %02h", got.byte_out, want.byte_out));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res %0b, wanted %0b", got.done_res, want.done_res));
      if (got.syntax_error !== want.syntax_error)
        report($sformatf("syntax_error %0b, wanted %0b",
                         got.syntax_error, want.syntax_error));
    endtask
  endclass

endpackage

// ===== verif/c_escape_sequence_decoder_tb.sv =====
// Testbench top for c_escape_sequence_decoder: directed and random C string
// literals, random gaps and stalls on both channels, word-by-word checking.
// Depends on ced_pkg, ced_tb_pkg and the decoder RTL.
module c_escape_sequence_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ced_pkg::*;
  import ced_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  decode_checker chk = new();
  int  items_sent = 0;
  bit  stim_done = 1'b0;
  int  tx_calm_left = 0;
  int  rx_calm_left = 0;
  int  rx_stall_left = 0;
  int  idle_cycles = 0;

  c_escape_sequence_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Gap before the next input word, with occasional gap-free stretches.
  function automatic int next_tx_gap();
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 4) begin
      tx_calm_left = $urandom_range(20, 100);
      return 0;
    end
    if ($urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1)) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] rand_oct_char();
    return 8'("0" + $urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] rand_non_oct();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (oct_digit(c) >= 0);
    return c;
  endfunction

  // Present one word after a random gap and hold it until it is taken.
  task automatic send_word(in_t w);
    int gap;
    gap = next_tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= in_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.decode_word(w);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    in_t w;
    w.char_in    = c;
    w.end_marker = 1'b0;
    send_word(w);
  endtask

  // The end marker carries a random character that the decoder must ignore.
  task automatic send_end();
    in_t w;
    w.char_in    = 8'($urandom_range(0, 255));
    w.end_marker = 1'b1;
    send_word(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // One random string: mostly well-formed escapes, some malformed ones,
  // and sometimes an escape cut short by the end marker.
  task automatic send_random_string();
    int segs;
    int r;
    segs = $urandom_range(1, 8);
    for (int i = 0; i < segs; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_char(8'($urandom_range(0, 255)));
      end else if (r < 45) begin
        send_char(CH_BACKSLASH);
        send_char(SIMPLE_LETTERS[$urandom_range(0, SIMPLE_LETTERS.len() - 1)]);
      end else if (r < 55) begin
        send_char(CH_BACKSLASH);
        send_char(8'($urandom_range(0, 255)));
      end else if (r < 72) begin
        send_char(CH_BACKSLASH);
        send_char(CH_LOWER_X);
        send_char(rand_hex_char());
        if ($urandom_range(0, 1)) send_char(rand_hex_char());
      end else if (r < 88) begin
        send_char(CH_BACKSLASH);
        repeat (3) send_char(rand_oct_char());
      end else begin
        send_char(CH_BACKSLASH);
        case ($urandom_range(0, 2))
          0: begin
            send_char(CH_LOWER_X);
            send_char(rand_non_hex());
          end
          1: begin
            send_char(rand_oct_char());
            send_char(rand_non_oct());
          end
          default: begin
            send_char(rand_oct_char());
            send_char(rand_oct_char());
            send_char(rand_non_oct());
          end
        endcase
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      send_char(CH_BACKSLASH);
      case ($urandom_range(0, 4))
        0: ;
        1: send_char(CH_LOWER_X);
        2: begin
          send_char(CH_LOWER_X);
          send_char(rand_hex_char());
        end
        3: send_char(rand_oct_char());
        default: begin
          send_char(rand_oct_char());
          send_char(rand_oct_char());
        end
      endcase
    end
    send_end();
  endtask

  // Output side: take and check words, with random stalls and calm stretches.
  always @(posedge clk) begin
    if (out_valid && out_ready) chk.check_word(out_data);
    if (rx_calm_left > 0) begin
      rx_calm_left--;
      out_ready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      rx_calm_left = $urandom_range(20, 150);
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      rx_stall_left = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: ends the run when nothing moves while work is outstanding.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (stim_done && chk.decoded_q.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus: reset, directed strings, then random strings.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Byte FF, simple escape, hex forms, bad first hex digit, hex closed by
    // a backslash, octal overflow, bad second octal digit, end after one hex digit.
    send_char(8'hFF);
    send_text("\\x41\\xg\\xa\\n\\401\\18\\xc");
    send_end();

    // Plain zero, backslash and zero, backslash and nine, end inside octal.
    send_char(8'h00);
    send_char(CH_BACKSLASH);
    send_char(8'h00);
    send_text("\\9\\7");
    send_end();

    while (items_sent < RANDOM_ITEMS) send_random_string();

    in_valid  <= 1'b0;
    stim_done = 1'b1;
    while (chk.decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (chk.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ced_pkg.sv
design/ced_front.sv
design/ced_queue.sv
design/ced_back.sv
design/c_escape_sequence_decoder.sv
verif/ced_tb_pkg.sv
verif/c_escape_sequence_decoder_tb.sv
